/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and held off
// during an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain property.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("concurrent assertion failed");

// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

/* hw/rtl/ele_pkg.sv */
// ----------------------------------------------------------------------------
// ele_pkg
// Shared types and constants of the echoing line editor.
// ----------------------------------------------------------------------------
package ele_pkg;

    localparam int LINE_DEPTH_DEF = 32;
    localparam int LEN_W          = 6;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

    localparam int FUNC_W     = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX    = 2'd0,
        FUNC_DRAIN = 2'd1,
        FUNC_LOCK  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    // Controller to datapath.
    typedef struct packed {
        logic       latch;       // capture the input item
        logic       exec;        // apply the item to the state
        logic       echo_load;   // load one echo result
        logic [1:0] step;        // position within the echo sequence
        logic       echo_last;   // this echo result ends the sequence
        logic       drain_load;  // load one drained byte or the terminator
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic       out_free;    // output register can take a result
        logic       exec_echo;   // item leads to an echo sequence
        logic       exec_drain;  // item leads to a drain
        logic [1:0] echo_len;    // results in the current echo sequence
        logic       drain_more;  // stored bytes still to send
    } t_sts;

endpackage

/* hw/rtl/ele_ctrl.sv */
// ----------------------------------------------------------------------------
// ele_ctrl
// Sequencer: takes one item, has it applied, then paces its results.
// ----------------------------------------------------------------------------
module ele_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ele_pkg::t_sts i_sts,
    output ele_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ECHO,
        S_DRAIN
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       r_in_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.latch      = r_in_ready && i_in_valid;
        o_cmd.exec       = (r_state == S_EXEC);
        o_cmd.echo_load  = (r_state == S_ECHO) && i_sts.out_free;
        o_cmd.step       = r_step;
        o_cmd.echo_last  = (r_step == (i_sts.echo_len - 2'd1));
        o_cmd.drain_load = (r_state == S_DRAIN) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.latch) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_step = 2'd0;
                if (i_sts.exec_echo) begin
                    n_state = S_ECHO;
                end else if (i_sts.exec_drain) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ECHO: begin
                if (i_sts.out_free) begin
                    if (o_cmd.echo_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end
            end
            S_DRAIN: begin
                if (i_sts.out_free && !i_sts.drain_more) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= 2'd0;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

/* hw/rtl/ele_dp.sv */
// ----------------------------------------------------------------------------
// ele_dp
// Line store, edit state, length register and output register.
// ----------------------------------------------------------------------------
module ele_dp #(
    parameter int LINE_DEPTH = ele_pkg::LINE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ele_pkg::LEN_W-1:0] i_cfg_len,
    input  logic [ele_pkg::FUNC_W-1:0] i_func,
    input  logic [7:0]                i_rx_byte,
    input  logic                      i_lock_value,
    input  ele_pkg::t_cmd             i_cmd,
    output ele_pkg::t_sts             o_sts,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic                      o_kind,
    output logic [7:0]                o_byte,
    output logic                      o_last,
    output logic                      o_line_ready,
    output logic                      o_status
);

    localparam int IDX_W  = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam logic [ele_pkg::LEN_W-1:0] DEPTH_LEN = ele_pkg::LEN_W'(LINE_DEPTH);
    localparam logic [IDX_W-1:0]          DEPTH_IDX = IDX_W'(LINE_DEPTH);

    typedef enum logic [2:0] {
        SEQ_BS,
        SEQ_CR,
        SEQ_CHAR,
        SEQ_NL,
        SEQ_REFUSE
    } t_seq;

    function automatic logic [7:0] echo_byte(t_seq seq, logic [1:0] step, logic [7:0] rx);
        logic [7:0] b;
        b = ele_pkg::CH_NUL;
        case (seq)
            SEQ_BS:   b = (step == 2'd1) ? ele_pkg::CH_SP : ele_pkg::CH_BS;
            SEQ_CR:   b = (step == 2'd1) ? ele_pkg::CH_LF : ele_pkg::CH_CR;
            SEQ_CHAR: b = rx;
            SEQ_NL:   b = (step == 2'd0) ? rx : ele_pkg::CH_CR;
            default:  b = ele_pkg::CH_NUL;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] echo_len(t_seq seq);
        logic [1:0] n;
        n = 2'd1;
        case (seq)
            SEQ_BS, SEQ_CR: n = 2'd3;
            SEQ_NL:         n = 2'd2;
            default:        n = 2'd1;
        endcase
        return n;
    endfunction

    // Control state
    logic [ele_pkg::LEN_W-1:0] r_len;
    logic [IDX_W-1:0]          r_widx;
    logic                      r_locked;
    logic                      r_o_valid;

    // Payload
    logic [ele_pkg::FUNC_W-1:0] r_func;
    logic [7:0]                 r_byte;
    logic                       r_lockv;
    t_seq                       r_seq;
    logic [IDX_W-1:0]           r_cnt;
    logic [7:0]                 r_rd_data;
    logic [7:0]                 r_mem [LINE_DEPTH];
    logic                       r_o_kind, r_o_last, r_o_ready, r_o_status;
    logic [7:0]                 r_o_byte;

    logic [ele_pkg::LEN_W-1:0] eff_len;
    logic [IDX_W-1:0]          widx_w, n_widx_exec, n_cnt;
    logic [ADDR_W-1:0]         rd_addr;
    t_seq                      n_seq;
    logic                      exec_echo, exec_drain, do_store, set_lock, lock_wr;
    logic                      drain_more, out_free;

    always_comb begin
        if (r_len == '0) begin
            eff_len = ele_pkg::LEN_W'(1);
        end else if (r_len > DEPTH_LEN) begin
            eff_len = DEPTH_LEN;
        end else begin
            eff_len = r_len;
        end
    end

    // Wrap before the edit when the index has run to the line length.
    assign widx_w = (ele_pkg::LEN_W'(r_widx) >= eff_len) ? '0 : r_widx;

    always_comb begin
        n_seq       = SEQ_REFUSE;
        exec_echo   = 1'b0;
        exec_drain  = 1'b0;
        do_store    = 1'b0;
        set_lock    = 1'b0;
        lock_wr     = 1'b0;
        n_widx_exec = r_widx;
        case (ele_pkg::t_func'(r_func))
            ele_pkg::FUNC_RX: begin
                if (!r_locked) begin
                    n_widx_exec = widx_w;
                    if (r_byte == ele_pkg::CH_BS) begin
                        if (widx_w != '0) begin
                            n_widx_exec = widx_w - IDX_W'(1);
                            n_seq       = SEQ_BS;
                            exec_echo   = 1'b1;
                        end
                    end else if (r_byte == ele_pkg::CH_CR) begin
                        n_seq     = SEQ_CR;
                        exec_echo = 1'b1;
                        set_lock  = 1'b1;
                    end else begin
                        do_store    = 1'b1;
                        n_widx_exec = widx_w + IDX_W'(1);
                        n_seq       = (r_byte == ele_pkg::CH_LF) ? SEQ_NL : SEQ_CHAR;
                        exec_echo   = 1'b1;
                    end
                end
            end
            ele_pkg::FUNC_DRAIN: begin
                if (r_locked) begin
                    exec_drain = 1'b1;
                end else begin
                    n_seq     = SEQ_REFUSE;
                    exec_echo = 1'b1;
                end
            end
            ele_pkg::FUNC_LOCK: lock_wr = 1'b1;
            default: ;
        endcase
    end

    assign drain_more = (r_cnt != r_widx);
    assign out_free   = !r_o_valid || i_out_ready;

    // Read port is addressed by the next drain position, so its registered data holds the current one.
    always_comb begin
        if (i_cmd.exec) begin
            n_cnt = '0;
        end else if (i_cmd.drain_load && drain_more) begin
            n_cnt = r_cnt + IDX_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
        rd_addr = (n_cnt < DEPTH_IDX) ? n_cnt[ADDR_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= ele_pkg::LEN_RESET;
            r_widx    <= '0;
            r_locked  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_len;
            end
            if (i_cmd.exec) begin
                r_widx <= n_widx_exec;
                if (set_lock) begin
                    r_locked <= 1'b1;
                end else if (lock_wr) begin
                    r_locked <= r_lockv;
                end
            end
            if (i_cmd.drain_load && !drain_more) begin
                r_widx <= '0;
            end
            if (i_cmd.echo_load || i_cmd.drain_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func  <= i_func;
            r_byte  <= i_rx_byte;
            r_lockv <= i_lock_value;
        end
        if (i_cmd.exec) begin
            r_seq <= n_seq;
        end
        if (i_cmd.exec && do_store) begin
            r_mem[widx_w[ADDR_W-1:0]] <= r_byte;
        end
        r_cnt     <= n_cnt;
        r_rd_data <= r_mem[rd_addr];
        if (i_cmd.echo_load) begin
            r_o_kind   <= (r_seq == SEQ_REFUSE);
            r_o_byte   <= echo_byte(r_seq, i_cmd.step, r_byte);
            r_o_last   <= i_cmd.echo_last;
            r_o_ready  <= (r_seq == SEQ_CR);
            r_o_status <= (r_seq == SEQ_REFUSE);
        end else if (i_cmd.drain_load) begin
            r_o_kind   <= 1'b1;
            r_o_byte   <= drain_more ? r_rd_data : ele_pkg::CH_NUL;
            r_o_last   <= !drain_more;
            r_o_ready  <= 1'b0;
            r_o_status <= 1'b0;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.out_free   = out_free;
        o_sts.exec_echo  = exec_echo;
        o_sts.exec_drain = exec_drain;
        o_sts.echo_len   = echo_len(r_seq);
        o_sts.drain_more = drain_more;
    end

    assign o_out_valid  = r_o_valid;
    assign o_kind       = r_o_kind;
    assign o_byte       = r_o_byte;
    assign o_last       = r_o_last;
    assign o_line_ready = r_o_ready;
    assign o_status     = r_o_status;

endmodule

/* hw/rtl/echoing_line_editor.sv */
// ----------------------------------------------------------------------------
// echoing_line_editor
// Canonical-mode terminal line editor with echo and line drain.
// ----------------------------------------------------------------------------
// Takes one item at a time on the slave stream. tuser selects the operation:
// a received byte is edited into the line store and echoed (backspace erases
// with BS SP BS, carriage return echoes CR LF CR and locks the line, newline
// echoes LF CR, any other byte echoes itself); a drain sends the stored line
// and a zero terminator on the master stream with tuser high, or one refusal
// result (status set) when the line is not locked; a lock write sets the lock
// flag. Bytes received while locked are dropped without a result. tlast marks
// the final result of each item. An item is captured, applied to the edit
// state, then sends its N results (0 to LINE_DEPTH + 1) one per cycle while
// the master stream is ready, through the single output register; the drain
// rate is set by the one read port of the line store, prefetched one entry
// ahead. tready returns in the cycle after the last result is loaded. The
// line store has no reset; only entries below the write index are ever read
// out. Write line_length only while the block is idle.
// ----------------------------------------------------------------------------
module echoing_line_editor #(
    parameter int LINE_DEPTH = ele_pkg::LINE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: line_length
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ele_pkg::LEN_W-1:0]     i_cfg_data,
    // Slave stream
    input  logic                          i_tvalid,
    output logic                          o_tready,
    input  logic [ele_pkg::IN_DATA_W-1:0] i_tdata,   // [7:0] rx_byte, [8] lock_value
    input  logic [ele_pkg::FUNC_W-1:0]    i_tuser,   // [1:0] func
    // Master stream
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [ele_pkg::OUT_DATA_W-1:0] o_tdata,  // [7:0] out_byte, [8] line_ready,
                                                     // [9] status
    output logic                          o_tuser,   // [0] stream_kind
    output logic                          o_tlast
);

    ele_pkg::t_cmd cmd;
    ele_pkg::t_sts sts;

    logic       out_ready_flag;
    logic       out_status;
    logic [7:0] out_byte;

    // Length register takes every transfer.
    assign o_cfg_ready = 1'b1;

    ele_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tvalid),
        .o_in_ready (o_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ele_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_len    (i_cfg_data),
        .i_func       (i_tuser),
        .i_rx_byte    (i_tdata[7:0]),
        .i_lock_value (i_tdata[8]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (i_tready),
        .o_out_valid  (o_tvalid),
        .o_kind       (o_tuser),
        .o_byte       (out_byte),
        .o_last       (o_tlast),
        .o_line_ready (out_ready_flag),
        .o_status     (out_status)
    );

    // Pack result fields, zero fill to whole bytes.
    assign o_tdata = ele_pkg::OUT_DATA_W'({out_status, out_ready_flag, out_byte});

endmodule

/* hw/rtl/ele_sva.sv */
// ----------------------------------------------------------------------------
// ele_sva
// Port-level checks of the echoing line editor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ele_sva (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_tvalid,
    input logic                           o_tready,
    input logic                           o_tvalid,
    input logic                           i_tready,
    input logic [ele_pkg::OUT_DATA_W-1:0] o_tdata,
    input logic                           o_tuser,
    input logic                           o_tlast
);

    // A refused drain is a lone terminator on the line stream.
    `ASSERT_CLK(a_refuse_form, i_clk, i_rst_n, (o_tvalid && o_tdata[9]) |-> (o_tlast && o_tuser && o_tdata[7:0] == 8'h00 && !o_tdata[8]))

    // Line-ready marks only carriage-return echo.
    `ASSERT_CLK(a_ready_on_echo, i_clk, i_rst_n, (o_tvalid && o_tdata[8]) |-> (!o_tuser && !o_tdata[9]))

    // One item at a time: ready drops after each input transfer.
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_tvalid && o_tready, !o_tready)

    // A stalled result holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_tvalid && !i_tready, o_tvalid && $stable(o_tdata) && $stable(o_tlast) && $stable(o_tuser))

endmodule

bind echoing_line_editor ele_sva u_ele_sva (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the echoing line editor. Items are sent on the
// slave stream under random gaps while the master stream stalls at random.
// Each accepted item runs through a local copy of the edit state, and every
// master transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH  = ele_pkg::LINE_DEPTH_DEF;
    localparam int ADDR_W = $clog2(DEPTH);

    // One slave-side item: operation, received character, lock value.
    typedef struct packed {
        ele_pkg::t_func func;
        logic [7:0]     rx_byte;
        logic           lock_value;
    } t_edit_item;

    // One master-side result.
    typedef struct packed {
        logic       stream_kind;
        logic [7:0] out_byte;
        logic       last;
        logic       line_ready;
        logic       status;
    } t_line_out;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ele_pkg::LEN_W-1:0]      i_cfg_data  = '0;
    logic                           i_tvalid    = 1'b0;
    logic                           o_tready;
    logic [ele_pkg::IN_DATA_W-1:0]  i_tdata     = '0;   // [7:0] rx_byte, [8] lock_value
    logic [ele_pkg::FUNC_W-1:0]     i_tuser     = '0;   // [1:0] func
    logic                           o_tvalid;
    logic                           i_tready    = 1'b0;
    logic [ele_pkg::OUT_DATA_W-1:0] o_tdata;    // [7:0] out_byte, [8] line_ready,
                                                // [9] status
    logic                           o_tuser;    // [0] stream_kind
    logic                           o_tlast;

    echoing_line_editor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_tvalid    (i_tvalid),
        .o_tready    (o_tready),
        .i_tdata     (i_tdata),
        .i_tuser     (i_tuser),
        .o_tvalid    (o_tvalid),
        .i_tready    (i_tready),
        .o_tdata     (o_tdata),
        .o_tuser     (o_tuser),
        .o_tlast     (o_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Keystrokes waiting to be sent, and echo/drain bytes awaited on the master side.
    t_edit_item keystroke_q [$];
    t_line_out  expected_tx_q [$];

    // Local copy of the editor state and of line_length.
    logic [7:0]                line_copy [DEPTH];
    logic [5:0]                wr_pos  = '0;
    logic                      locked  = 1'b0;
    logic [ele_pkg::LEN_W-1:0] len_reg = ele_pkg::LEN_RESET;

    int         bad_count = 0;
    t_edit_item on_wire;
    t_line_out  seen_out;
    t_line_out  want_out;
    int         send_pause = 0;
    int         send_calm  = 0;
    int         hold_off   = 0;
    int         recv_calm  = 0;

    function automatic t_line_out mk_out(logic kind, logic [7:0] b, logic rdy, logic st);
        t_line_out o;
        o.stream_kind = kind;
        o.out_byte    = b;
        o.last        = 1'b0;
        o.line_ready  = rdy;
        o.status      = st;
        return o;
    endfunction

    // Apply one accepted item to the local state and queue what it must emit.
    task automatic edit_line(input t_edit_item it);
        t_line_out burst [$];
        int        span;
        // A length of zero behaves as one, anything past the store as the store.
        span = (len_reg == '0) ? 1 : ((int'(len_reg) > DEPTH) ? DEPTH : int'(len_reg));
        case (it.func)
            ele_pkg::FUNC_RX: begin
                if (!locked) begin
                    if (int'(wr_pos) >= span) wr_pos = '0;
                    if (it.rx_byte == ele_pkg::CH_BS) begin
                        // Erase only when something is stored; an empty line stays silent.
                        if (wr_pos != '0) begin
                            wr_pos = wr_pos - 6'd1;
                            burst.push_back(mk_out(1'b0, ele_pkg::CH_BS, 1'b0, 1'b0));
                            burst.push_back(mk_out(1'b0, ele_pkg::CH_SP, 1'b0, 1'b0));
                            burst.push_back(mk_out(1'b0, ele_pkg::CH_BS, 1'b0, 1'b0));
                        end
                    end else if (it.rx_byte == ele_pkg::CH_CR) begin
                        burst.push_back(mk_out(1'b0, ele_pkg::CH_CR, 1'b1, 1'b0));
                        burst.push_back(mk_out(1'b0, ele_pkg::CH_LF, 1'b1, 1'b0));
                        burst.push_back(mk_out(1'b0, ele_pkg::CH_CR, 1'b1, 1'b0));
                        locked = 1'b1;
                    end else begin
                        if (int'(wr_pos) < DEPTH) line_copy[wr_pos[ADDR_W-1:0]] = it.rx_byte;
                        wr_pos = wr_pos + 6'd1;
                        burst.push_back(mk_out(1'b0, it.rx_byte, 1'b0, 1'b0));
                        if (it.rx_byte == ele_pkg::CH_LF)
                            burst.push_back(mk_out(1'b0, ele_pkg::CH_CR, 1'b0, 1'b0));
                    end
                end
            end
            ele_pkg::FUNC_DRAIN: begin
                if (!locked) begin
                    burst.push_back(mk_out(1'b1, ele_pkg::CH_NUL, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < int'(wr_pos) && i < DEPTH; i++)
                        burst.push_back(mk_out(1'b1, line_copy[i[ADDR_W-1:0]], 1'b0, 1'b0));
                    burst.push_back(mk_out(1'b1, ele_pkg::CH_NUL, 1'b0, 1'b0));
                    wr_pos = '0;
                end
            end
            ele_pkg::FUNC_LOCK: locked = it.lock_value;
            ele_pkg::FUNC_NONE: ;
            default: ;
        endcase
        if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) expected_tx_q.push_back(burst[i]);
    endtask

    // Mostly no pause, sometimes a short one, rarely a long one; now and then
    // a calm stretch with no pauses at all.
    function automatic int next_pause(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 2) begin
            calm = int'($urandom_range(30, 80));
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return int'($urandom_range(1, 3));
        if (r < 96) return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 45));
    endfunction

    // Slave-side driver: hold each item until its transfer, then pause at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_tvalid <= 1'b0;
        end else begin
            if (i_tvalid && o_tready) edit_line(on_wire);
            if (!i_tvalid || o_tready) begin
                if (send_pause > 0) begin
                    send_pause--;
                    i_tvalid <= 1'b0;
                end else if (keystroke_q.size() != 0) begin
                    on_wire = keystroke_q.pop_front();
                    i_tdata  <= {7'd0, on_wire.lock_value, on_wire.rx_byte};
                    i_tuser  <= on_wire.func;
                    i_tvalid <= 1'b1;
                    send_pause = next_pause(send_calm);
                end else begin
                    i_tvalid <= 1'b0;
                end
            end
        end
    end

    // Master-side monitor: check every transfer, then stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_tready <= 1'b0;
        end else begin
            if (o_tvalid && i_tready) begin
                seen_out.stream_kind = o_tuser;
                seen_out.out_byte    = o_tdata[7:0];
                seen_out.line_ready  = o_tdata[8];
                seen_out.status      = o_tdata[9];
                seen_out.last        = o_tlast;
                if (expected_tx_q.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected transfer: kind=%0d byte=%02h last=%0d ready=%0d status=%0d",
                                 seen_out.stream_kind, seen_out.out_byte, seen_out.last,
                                 seen_out.line_ready, seen_out.status);
                end else begin
                    want_out = expected_tx_q.pop_front();
                    if (seen_out !== want_out) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $write("mismatch: expected kind=%0d byte=%02h last=%0d ready=%0d status=%0d,",
                                   want_out.stream_kind, want_out.out_byte, want_out.last,
                                   want_out.line_ready, want_out.status);
                            $display(" got kind=%0d byte=%02h last=%0d ready=%0d status=%0d",
                                     seen_out.stream_kind, seen_out.out_byte, seen_out.last,
                                     seen_out.line_ready, seen_out.status);
                        end
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                i_tready <= 1'b0;
            end else begin
                i_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold_off = next_pause(recv_calm);
            end
        end
    end

    task automatic add_key(input ele_pkg::t_func f, input logic [7:0] b, input logic lv);
        t_edit_item it;
        it.func       = f;
        it.rx_byte    = b;
        it.lock_value = lv;
        keystroke_q.push_back(it);
    endtask

    // Wait until every item is sent and every result seen, then let an item
    // with no result finish inside the block.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (keystroke_q.size() != 0 || i_tvalid || expected_tx_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_line_length(input logic [ele_pkg::LEN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        len_reg = v;
    endtask

    // Mostly whole lines (unlock, type, CR, drain) with random content; the
    // rest is random noise that hits locked drops, refused drains and unused ops.
    task automatic random_traffic(input int budget);
        int         added;
        int         n;
        int         r;
        logic [7:0] ch;
        added = 0;
        while (added < budget) begin
            if ($urandom_range(0, 9) < 7) begin
                add_key(ele_pkg::FUNC_LOCK, 8'($urandom_range(0, 255)), 1'b0);
                // Long lines now and then so the write index wraps.
                n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(13, 40))
                                                : int'($urandom_range(0, 12));
                repeat (n) begin
                    r = int'($urandom_range(0, 99));
                    if (r < 10)      ch = ele_pkg::CH_BS;
                    else if (r < 13) ch = ele_pkg::CH_LF;
                    else if (r < 18) ch = 8'($urandom_range(0, 255));
                    else             ch = 8'($urandom_range(32, 126));
                    add_key(ele_pkg::FUNC_RX, ch, 1'($urandom_range(0, 1)));
                end
                add_key(ele_pkg::FUNC_RX, ele_pkg::CH_CR, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 2) == 0)
                    add_key(ele_pkg::FUNC_RX, 8'($urandom_range(0, 255)), 1'b1);
                add_key(ele_pkg::FUNC_DRAIN, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
                added += n + 3;
            end else begin
                n = int'($urandom_range(1, 4));
                repeat (n)
                    add_key(ele_pkg::t_func'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
                added += n;
            end
        end
    endtask

    initial begin
        logic [ele_pkg::LEN_W-1:0] lengths [6];
        lengths = '{6'd0, 6'd63, 6'd1, 6'd32, 6'd5, 6'd0};
        lengths[5] = ele_pkg::LEN_W'($urandom_range(2, 31));
        for (int i = 0; i < DEPTH; i++) line_copy[i[ADDR_W-1:0]] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset length.
        add_key(ele_pkg::FUNC_DRAIN, 8'hA5, 1'b1);          // refused: line not locked
        add_key(ele_pkg::FUNC_RX,    ele_pkg::CH_BS, 1'b0);  // erase on empty line: silent
        add_key(ele_pkg::FUNC_RX,    ele_pkg::CH_NUL, 1'b0); // zero byte is stored
        add_key(ele_pkg::FUNC_RX,    8'hFF, 1'b1);
        add_key(ele_pkg::FUNC_RX,    ele_pkg::CH_LF, 1'b0);  // newline adds a CR echo
        add_key(ele_pkg::FUNC_RX,    8'h41, 1'b0);
        add_key(ele_pkg::FUNC_RX,    ele_pkg::CH_BS, 1'b1);  // erase the last byte
        add_key(ele_pkg::FUNC_NONE,  8'h5A, 1'b1);          // unused op: ignored
        add_key(ele_pkg::FUNC_LOCK,  8'h00, 1'b1);
        add_key(ele_pkg::FUNC_RX,    8'h42, 1'b0);          // dropped while locked
        add_key(ele_pkg::FUNC_DRAIN, 8'h00, 1'b0);
        add_key(ele_pkg::FUNC_DRAIN, 8'hFF, 1'b0);          // nothing left: terminator only
        add_key(ele_pkg::FUNC_LOCK,  8'hFF, 1'b0);
        add_key(ele_pkg::FUNC_RX,    8'h61, 1'b0);
        add_key(ele_pkg::FUNC_RX,    8'h62, 1'b0);
        add_key(ele_pkg::FUNC_RX,    ele_pkg::CH_CR, 1'b0);  // completes and locks the line
        add_key(ele_pkg::FUNC_RX,    ele_pkg::CH_CR, 1'b1);  // dropped while locked
        add_key(ele_pkg::FUNC_DRAIN, 8'h00, 1'b0);
        add_key(ele_pkg::FUNC_LOCK,  8'h00, 1'b0);
        add_key(ele_pkg::FUNC_RX,    ele_pkg::CH_CR, 1'b0);  // empty line
        add_key(ele_pkg::FUNC_DRAIN, 8'h00, 1'b0);
        add_key(ele_pkg::FUNC_LOCK,  8'h00, 1'b0);
        wait_idle();

        // Random phases, each under its own line_length, extremes included.
        foreach (lengths[p]) begin
            set_line_length(lengths[p]);
            random_traffic(50);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        bad_count += expected_tx_q.size();
        if (bad_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
